// ===== rtl/rhc_pkg.sv =====
// Shared types, constants and table functions for the rolling hash chunk cutter.
// No dependencies; used by the top level and the testbench.
`timescale 1ns / 1ps

package rhc_pkg;

	localparam int LEN_W    = 19;
	localparam int NODE_W   = 4;
	localparam int REASON_W = 2;
	localparam int CFG_W    = 19;
	localparam int CFG_IDX_W = 2;
	localparam int MASK_W   = 5;
	localparam int NCOUNT_W = 5;
	localparam int FP_W     = 64;

	localparam int WINDOW_BYTES_DEF    = 48;
	localparam int MAX_CHUNK_LIMIT_DEF = 262144;
	localparam int NODE_LIMIT_DEF      = 16;

	localparam logic [FP_W-1:0] RABIN_POLY = 64'h003D_A335_8B4D_C173;

	localparam logic [MASK_W-1:0]   MASK_BITS_RST  = 5'd16;
	localparam logic [CFG_W-1:0]    MAX_LENGTH_RST = 19'd262144;
	localparam logic [NCOUNT_W-1:0] NODE_TOTAL_RST = 5'd1;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MASK_BITS  = 2'd0,
		REG_MAX_LENGTH = 2'd1,
		REG_NODE_TOTAL = 2'd2
	} reg_index_t;

	typedef enum logic [REASON_W-1:0] {
		CUT_MATCH  = 2'd0,
		CUT_MAXLEN = 2'd1,
		CUT_EOF    = 2'd2
	} cut_reason_t;

	typedef struct packed {
		logic [LEN_W-1:0]  length;
		logic [NODE_W-1:0] node;
		cut_reason_t       reason;
	} result_t;

	// Reduction of one byte modulo the Rabin polynomial (bit-reflected form).
	function automatic logic [FP_W-1:0] poly_entry(input logic [7:0] b);
		logic [FP_W-1:0] v;
		v = {{(FP_W-8){1'b0}}, b};
		for (int i = 0; i < 8; i++) begin
			v = v[0] ? ((v >> 1) ^ RABIN_POLY) : (v >> 1);
		end
		return v;
	endfunction

	function automatic logic [FP_W-1:0] push_byte(input logic [FP_W-1:0] h,
	                                              input logic [7:0] b);
		return (h << 8) ^ poly_entry(h[FP_W-1:FP_W-8] ^ b);
	endfunction

	// Hash of byte b followed by wb-1 zero bytes: the contribution of the oldest byte.
	function automatic logic [FP_W-1:0] leaving_term(input logic [7:0] b, input int wb);
		logic [FP_W-1:0] h;
		h = push_byte('0, b);
		for (int i = 0; i < wb - 1; i++) begin
			h = push_byte(h, 8'd0);
		end
		return h;
	endfunction

endpackage

// ===== rtl/rhc_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// Read-first on a same-address collision. No dependencies.
`timescale 1ns / 1ps

module rhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rolling_hash_chunk_cutter.sv =====
// Top level of the rolling hash chunk cutter: window RAM, fingerprint update,
// cut decision and a two-entry result queue. Depends on rhc_pkg and rhc_ram.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid/in_ready): one file byte per item, with end_of_file
//   set on the last byte of a file.
// - Output channel (out_valid/out_ready): one item per closed chunk carrying its
//   length, round-robin node and cut reason (match, max length, end of file).
// - Config port: cfg_we with cfg_index/cfg_data writes mask_bits, max_length or
//   node_total; write only while the block is idle.
// - Throughput: one byte per cycle sustained while in_ready holds. The leaving
//   window byte is read from the window RAM at accept, and the fingerprint, length
//   and node registers are updated in the following cycle: the roll loops on fp_q.
// - Path: at accept the RAM read and the stage-1 registers capture the byte; the
//   fingerprint stage then pushes its result into the result queue, from which
//   the output channel offers it.
// - Stalls: results sit in a two-entry queue; in_ready drops only when the queue
//   plus the byte in flight could overflow it, so a stalled receiver back-pressures
//   the input without losing or duplicating a result.
// - Reset: arst_n clears fingerprint, length, window pointer, node index and the
//   window valid bits (the window reads as all zeros); registers take defaults.
//   No clearing pass is needed. End of file clears the window the same way.

module rolling_hash_chunk_cutter #(
	parameter int WINDOW_BYTES    = rhc_pkg::WINDOW_BYTES_DEF,
	parameter int MAX_CHUNK_LIMIT = rhc_pkg::MAX_CHUNK_LIMIT_DEF,
	parameter int NODE_LIMIT      = rhc_pkg::NODE_LIMIT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// config
	input  logic                           cfg_we,
	input  logic [rhc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rhc_pkg::CFG_W-1:0]      cfg_data,
	// input bytes
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           end_of_file,
	// chunk results
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rhc_pkg::LEN_W-1:0]      chunk_length,
	output logic [rhc_pkg::NODE_W-1:0]     target_node,
	output logic [rhc_pkg::REASON_W-1:0]   cut_reason
);

	localparam int PTR_W = $clog2(WINDOW_BYTES);
	localparam int LEN_W = rhc_pkg::LEN_W;
	localparam int NODE_W = rhc_pkg::NODE_W;
	localparam int FP_W = rhc_pkg::FP_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_BYTES - 1);

	// ------------------------------------------------------------------
	// Config registers
	// ------------------------------------------------------------------
	logic [rhc_pkg::MASK_W-1:0]   mask_bits_q;
	logic [rhc_pkg::CFG_W-1:0]    max_length_q;
	logic [rhc_pkg::NCOUNT_W-1:0] node_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_bits_q  <= rhc_pkg::MASK_BITS_RST;
			max_length_q <= rhc_pkg::MAX_LENGTH_RST;
			node_total_q <= rhc_pkg::NODE_TOTAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rhc_pkg::REG_MASK_BITS:  mask_bits_q  <= cfg_data[rhc_pkg::MASK_W-1:0];
				rhc_pkg::REG_MAX_LENGTH: max_length_q <= cfg_data;
				rhc_pkg::REG_NODE_TOTAL: node_total_q <= cfg_data[rhc_pkg::NCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Constant tables: reduction per byte, and leaving-byte contribution
	// ------------------------------------------------------------------
	logic [FP_W-1:0] pe_tab [256];
	logic [FP_W-1:0] lt_tab [256];

	for (genvar gi = 0; gi < 256; gi++) begin : g_tab
		localparam logic [FP_W-1:0] PE = rhc_pkg::poly_entry(8'(gi));
		localparam logic [FP_W-1:0] LT = rhc_pkg::leaving_term(8'(gi), WINDOW_BYTES);
		assign pe_tab[gi] = PE;
		assign lt_tab[gi] = LT;
	end

	// ------------------------------------------------------------------
	// Accept: window RAM read of the oldest byte, write of the new one
	// ------------------------------------------------------------------
	logic                    in_fire;
	logic [PTR_W-1:0]        ptr_q;
	logic [WINDOW_BYTES-1:0] win_valid_q;   // cleared entries read as zero
	logic [7:0]              old_raw;

	assign in_fire = in_valid && in_ready;

	rhc_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_BYTES)
	) u_window (
		.clk  (clk),
		.we   (in_fire),
		.waddr(ptr_q),
		.wdata(data_byte),
		.re   (in_fire),
		.raddr(ptr_q),
		.rdata(old_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			win_valid_q <= '0;
		end else if (in_fire) begin
			if (end_of_file) begin
				ptr_q       <= '0;
				win_valid_q <= '0;
			end else begin
				ptr_q              <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
				win_valid_q[ptr_q] <= 1'b1;
			end
		end
	end

	// stage 1 item
	logic       s1_v_q;
	logic [7:0] byte_s1;
	logic       eof_s1;
	logic       old_valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else begin
			s1_v_q <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1      <= data_byte;
			eof_s1       <= end_of_file;
			old_valid_s1 <= win_valid_q[ptr_q];
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: roll the fingerprint, count, decide the cut
	// ------------------------------------------------------------------
	logic [FP_W-1:0]   fp_q;
	logic [LEN_W-1:0]  chunk_q;
	logic [NODE_W-1:0] node_q;

	logic [7:0]        old_byte;
	logic [FP_W-1:0]   fp_rem;
	logic [FP_W-1:0]   fp_new;
	logic [FP_W-1:0]   fp_mask;
	logic [LEN_W-1:0]  cnt_new;
	logic [LEN_W-1:0]  len_limit;
	logic [8:0]        node_lim;
	logic [NODE_W-1:0] node_adv;
	logic              match;
	logic              forced;
	logic              cut;
	logic              push;
	rhc_pkg::result_t  res;

	assign old_byte = old_valid_s1 ? old_raw : 8'd0;
	assign fp_rem   = fp_q ^ lt_tab[old_byte];
	assign fp_new   = (fp_rem << 8) ^ pe_tab[fp_rem[FP_W-1:FP_W-8] ^ byte_s1];
	assign fp_mask  = (64'd1 << mask_bits_q) - 64'd1;
	assign cnt_new  = (chunk_q != rhc_pkg::LEN_MAX) ? chunk_q + 1'b1 : chunk_q;

	// a max length below the window size simply cuts at window+1 (gated below)
	assign len_limit = (32'(max_length_q) > MAX_CHUNK_LIMIT) ?
	                   LEN_W'(MAX_CHUNK_LIMIT) : max_length_q;

	// node count of zero acts as one
	always_comb begin
		if (node_total_q == '0) begin
			node_lim = 9'd1;
		end else if (32'(node_total_q) > NODE_LIMIT) begin
			node_lim = 9'(NODE_LIMIT);
		end else begin
			node_lim = 9'(node_total_q);
		end
	end

	assign node_adv = (9'(node_q) + 9'd1 >= node_lim) ? '0 : node_q + 1'b1;

	assign match  = (fp_new & fp_mask) == '0;
	assign forced = cnt_new >= len_limit;
	assign cut    = (cnt_new > LEN_W'(WINDOW_BYTES)) && (match || forced);
	assign push   = s1_v_q && (cut || eof_s1);

	always_comb begin
		res.length = cnt_new;
		res.node   = node_q;
		if (!cut) begin
			res.reason = rhc_pkg::CUT_EOF;
		end else if (match) begin
			res.reason = rhc_pkg::CUT_MATCH;
		end else begin
			res.reason = rhc_pkg::CUT_MAXLEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q    <= '0;
			chunk_q <= '0;
			node_q  <= '0;
		end else if (s1_v_q) begin
			if (cut) begin
				node_q <= node_adv;
			end
			if (eof_s1) begin
				fp_q    <= '0;
				chunk_q <= '0;
			end else begin
				fp_q    <= fp_new;
				chunk_q <= cut ? '0 : cnt_new;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result queue, two entries
	// ------------------------------------------------------------------
	rhc_pkg::result_t ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] out_cnt_q;
	logic       pop;
	logic [2:0] load;

	assign out_valid = out_cnt_q != 2'd0;
	assign pop       = out_valid && out_ready;

	// room for the byte in flight plus the one being offered
	assign load     = 3'(out_cnt_q) + 3'(s1_v_q);
	assign in_ready = load <= (3'd1 + 3'(pop));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			out_cnt_q <= out_cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= res;
		end
	end

	assign chunk_length = ent_q[rd_ptr_q].length;
	assign target_node  = ent_q[rd_ptr_q].node;
	assign cut_reason   = ent_q[rd_ptr_q].reason;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= 2'd2)
		else $error("result queue over capacity");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> out_cnt_q < 2'd2)
		else $error("result pushed into a full queue");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ptr_q) < WINDOW_BYTES)
		else $error("window pointer out of range");

	a_eof_window: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && end_of_file |=> win_valid_q == '0 && ptr_q == '0)
		else $error("window not cleared after end of file");

	a_eof_state: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && eof_s1 |=> fp_q == '0 && chunk_q == '0)
		else $error("fingerprint or length not cleared after end of file");

endmodule

// ===== tb/rolling_hash_chunk_cutter_tb.sv =====
// Self-checking testbench for the rolling hash chunk cutter: random file streams
// against a table-driven fingerprint predictor. Depends on rhc_pkg and the RTL.
`timescale 1ns / 1ps

module rolling_hash_chunk_cutter_tb;
	import rhc_pkg::*;

	localparam int WIN           = WINDOW_BYTES_DEF;
	localparam int SETTLE_CYCLES = 6;       // slack for bytes in flight after the last chunk is out
	localparam int HOLD_CYCLES   = 300;     // long receiver hold-off to back up the block
	localparam int REPORT_CAP    = 100;     // mismatches printed before going quiet
	localparam int TIMEOUT_NS    = 2_000_000;
	localparam int PHASES        = 7;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

	// Predicts the chunk cuts from the byte stream and holds those not yet seen.
	class chunk_cut_predictor;
		logic [FP_W-1:0]     reduce_tab [256];
		logic [FP_W-1:0]     leave_tab [256];
		logic [FP_W-1:0]     fp;
		logic [7:0]          window [WIN];
		int unsigned         wpos;
		logic [LEN_W-1:0]    run_len;
		logic [NODE_W-1:0]   node_idx;
		logic [MASK_W-1:0]   mask_bits;
		logic [CFG_W-1:0]    max_len;
		logic [NCOUNT_W-1:0] node_cnt;
		result_t             pending_cuts [$];
		int unsigned         errors;

		function new();
			logic [FP_W-1:0] v;
			// byte reduction table, bit-reflected polynomial
			for (int i = 0; i < 256; i++) begin
				v = FP_W'(i);
				for (int k = 0; k < 8; k++)
					v = v[0] ? ((v >> 1) ^ RABIN_POLY) : (v >> 1);
				reduce_tab[i] = v;
			end
			// contribution of a byte once it is the oldest in the window
			for (int i = 0; i < 256; i++) begin
				v = roll('0, 8'(i));
				for (int k = 1; k < WIN; k++)
					v = roll(v, 8'd0);
				leave_tab[i] = v;
			end
			mask_bits = MASK_BITS_RST;
			max_len   = MAX_LENGTH_RST;
			node_cnt  = NODE_TOTAL_RST;
			node_idx  = '0;
			errors    = 0;
			clear_window();
		endfunction

		function logic [FP_W-1:0] roll(logic [FP_W-1:0] h, logic [7:0] b);
			return (h << 8) ^ reduce_tab[h[FP_W-1:FP_W-8] ^ b];
		endfunction

		function void clear_window();
			fp      = '0;
			wpos    = 0;
			run_len = '0;
			foreach (window[i])
				window[i] = 8'd0;
		endfunction

		function void write_reg(reg_index_t idx, logic [CFG_W-1:0] d);
			case (idx)
				REG_MASK_BITS:  mask_bits = d[MASK_W-1:0];
				REG_MAX_LENGTH: max_len   = d;
				REG_NODE_TOTAL: node_cnt  = d[NCOUNT_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_byte(logic [7:0] b, logic eof);
			int unsigned     lim, cnt;
			logic [FP_W-1:0] m;
			logic            hit, forced, cut;
			result_t         r;
			fp = roll(fp ^ leave_tab[window[wpos]], b);
			window[wpos] = b;
			wpos = (wpos + 1 == WIN) ? 0 : wpos + 1;
			if (run_len != LEN_MAX)
				run_len++;
			// out-of-range settings are clamped, never rejected
			lim = (max_len > MAX_CHUNK_LIMIT_DEF) ? MAX_CHUNK_LIMIT_DEF : max_len;
			cnt = (node_cnt == 0) ? 1 :
			      ((node_cnt > NODE_LIMIT_DEF) ? NODE_LIMIT_DEF : node_cnt);
			m = (64'd1 << mask_bits) - 64'd1;
			cut = 1'b0;
			if (run_len > WIN) begin
				hit    = (fp & m) == '0;
				forced = run_len >= lim;
				if (hit || forced) begin
					r.length = run_len;
					r.node   = node_idx;
					r.reason = hit ? CUT_MATCH : CUT_MAXLEN;
					pending_cuts.push_back(r);
					cut = 1'b1;
					// an index left above a shrunk count is used once, then wraps
					node_idx = (int'(node_idx) + 1 >= cnt) ? '0 : node_idx + 1'b1;
					run_len  = '0;
				end
			end
			if (eof) begin
				if (!cut && run_len != 0) begin
					r.length = run_len;
					r.node   = node_idx;
					r.reason = CUT_EOF;
					pending_cuts.push_back(r);
				end
				clear_window();
			end
		endfunction

		function bit log_err();
			errors++;
			return errors <= REPORT_CAP;
		endfunction

		function void check_cut(logic [LEN_W-1:0] len, logic [NODE_W-1:0] node,
		                        logic [REASON_W-1:0] why);
			result_t want;
			if (pending_cuts.size() == 0) begin
				if (log_err())
					$display("%0t: unexpected chunk: expected none, got len %0d node %0d reason %0d",
					         $time, len, node, why);
				return;
			end
			want = pending_cuts.pop_front();
			if (want.length !== len && log_err())
				$display("%0t: chunk_length expected %0d got %0d", $time, want.length, len);
			if (want.node !== node && log_err())
				$display("%0t: target_node expected %0d got %0d", $time, want.node, node);
			if (want.reason !== why && log_err())
				$display("%0t: cut_reason expected %0d got %0d", $time, want.reason, why);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [7:0]          data_byte;
	logic                end_of_file;
	logic                out_valid;
	logic                out_ready;
	logic [LEN_W-1:0]    chunk_length;
	logic [NODE_W-1:0]   target_node;
	logic [REASON_W-1:0] cut_reason;

	chunk_cut_predictor cuts;
	bit                 hold_req = 1'b0;   // asks the receiver for one long hold-off
	int unsigned        burst_left = 0;

	rolling_hash_chunk_cutter u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_file  (end_of_file),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chunk_length (chunk_length),
		.target_node  (target_node),
		.cut_reason   (cut_reason)
	);

	always #2 clk = ~clk;

	// Output monitor: values read at the edge are the ones the block saw.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1)
			cuts.check_cut(chunk_length, target_node, cut_reason);
	end

	// Receiver: stall pattern changes every stretch; one long hold on request.
	initial begin : receiver
		rx_mode_t    mode;
		int unsigned stretch, hold_left;
		bit          hold_used;
		out_ready = 1'b0;
		mode      = RX_OPEN;
		stretch   = 0;
		hold_left = 0;
		hold_used = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (stretch == 0) begin
				mode    = rx_mode_t'($urandom_range(0, 3));
				stretch = $urandom_range(10, 150);
			end
			stretch--;
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= (stretch % 5) < 3;
				endcase
			end
		end
	end

	// Offers one item and returns at the edge where it is taken. Bursts of random
	// length, sometimes long unbroken runs, with random gaps in between.
	task automatic send_byte(input logic [7:0] b, input logic eof);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? 300 : $urandom_range(1, 40);
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		data_byte   <= b;
		end_of_file <= eof;
		do @(posedge clk); while (in_ready !== 1'b1);
		cuts.take_byte(b, eof);
	endtask

	// Stop sending until every predicted chunk is out, then let bytes in flight settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (cuts.pending_cuts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		cuts.write_reg(idx, val);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// 5-bit registers ignore the upper data bits; fill them with noise.
	function automatic logic [CFG_W-1:0] with_junk(input logic [4:0] v);
		logic [CFG_W-6:0] junk;
		junk = (CFG_W - 5)'($urandom_range(0, (1 << (CFG_W - 5)) - 1));
		return {junk, v};
	endfunction

	// Files of random length and content. A few are left open so the chunk runs
	// on into the next file; some are exactly one window plus one byte long.
	task automatic send_files(input int unsigned n_bytes);
		int unsigned sent, flen, pick;
		logic [7:0]  fill, b;
		logic        closed;
		sent = 0;
		while (sent < n_bytes) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				flen = WIN + 1;
			else if (pick < 3)
				flen = $urandom_range(1, 8);
			else if (pick < 8)
				flen = $urandom_range(WIN + 1, 160);
			else
				flen = $urandom_range(160, 400);
			if (flen > n_bytes - sent)
				flen = n_bytes - sent;
			closed = ($urandom_range(0, 9) != 0);
			fill   = 8'($urandom_range(0, 255));
			for (int k = 0; k < flen; k++) begin
				// mostly random bytes, now and then a repeated fill value
				b = ($urandom_range(0, 7) == 0) ? fill : 8'($urandom_range(0, 255));
				send_byte(b, closed && (k == flen - 1));
			end
			sent += flen;
		end
	endtask

	initial begin : stimulus
		// mask_bits, max_length, node total and byte count per phase; includes
		// zero and over-wide mask, lengths below the window and above the cap,
		// zero and oversized node counts, and the legal extremes
		logic [4:0]       ph_mask  [PHASES] = '{5'd0, 5'd31, 5'd1, 5'd18, 5'd4, 5'd3, 5'd6};
		logic [CFG_W-1:0] ph_len   [PHASES] = '{19'd0, 19'd60, 19'd524287, 19'd262144,
		                                        19'd49, 19'd100, 19'd200};
		logic [4:0]       ph_nodes [PHASES] = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd5, 5'd16};
		int unsigned      ph_items [PHASES] = '{250, 200, 250, 200, 250, 300, 500};
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_MASK_BITS;
		cfg_data    = '0;
		in_valid    = 1'b0;
		data_byte   = 8'd0;
		end_of_file = 1'b0;
		cuts        = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: short files that close only at end of file.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_MASK_BITS, with_junk(ph_mask[p]));
			write_reg(REG_MAX_LENGTH, ph_len[p]);
			write_reg(REG_NODE_TOTAL, with_junk(ph_nodes[p]));
			// First phase cuts every window plus one byte: a long receiver hold
			// here fills the result queue and must stall the input.
			if (p == 0)
				hold_req = 1'b1;
			send_files(ph_items[p]);
			drain();
		end

		if (cuts.errors == 0 && cuts.pending_cuts.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : watchdog
		#TIMEOUT_NS;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
